@@ src/sbsph_pkg.sv @@
// ============================================================================
// sbsph_pkg
// Shared widths, constants, configuration layout and item metadata for the
// spectrum bin smoother with peak hold.
// ============================================================================
`timescale 1ns / 1ps

package sbsph_pkg;

    localparam int MAX_BINS      = 4096;
    localparam int MAG_WIDTH     = 32;
    localparam int BIN_W         = 12;
    localparam int ADDR_W        = $clog2(MAX_BINS);
    localparam int CNT_W         = $clog2(MAX_BINS + 1);
    localparam int POS_W         = $clog2(MAG_WIDTH);
    localparam int DB_W          = 16;
    localparam int COEFF_W       = 16;
    localparam int ORDER_W       = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int MAG_FRAC_BITS = 16;

    // Log2 mantissa is Q1.30; one squaring stage per fraction bit.
    localparam int MANT_FRAC     = 30;
    localparam int MANT_W        = MANT_FRAC + 1;
    localparam int FRAC_W        = 16;
    localparam int LOG2_STAGES   = FRAC_W;

    // dB conversion: 20*log10(2) in Q.16, product rounded by 2^24.
    localparam int DBK_W         = 20;
    localparam logic [DBK_W-1:0] DB_PER_LOG2 = 20'd394566;
    localparam int DB_SHIFT      = 24;

    // Register stages of the dB unit: input, msb search, normalize,
    // squarings, scale multiply, round and clamp.
    localparam int DB_LAT        = LOG2_STAGES + 5;

    localparam logic [1:0] OP_PROCESS    = 2'd0;
    localparam logic [1:0] OP_CLEAR_PEAK = 2'd1;
    localparam logic [1:0] OP_CLEAR_ALL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FFT_ORDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DB    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DB    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 3'd5;

    localparam logic signed [DB_W-1:0] RESET_MIN_DB = -16'sd25600;

    typedef struct packed {
        logic [ORDER_W-1:0]        fft_order;
        logic signed [DB_W-1:0]    min_db;
        logic signed [DB_W-1:0]    max_db;
        logic [COEFF_W-1:0]        attack_coeff;
        logic [COEFF_W-1:0]        release_coeff;
        logic [COEFF_W-1:0]        decay_factor;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        fft_order:     4'd12,
        min_db:        RESET_MIN_DB,
        max_db:        16'sd0,
        attack_coeff:  16'd65535,
        release_coeff: 16'd39650,
        decay_factor:  16'd63570
    };

    typedef struct packed {
        logic             valid;
        logic [1:0]       op;
        logic [BIN_W-1:0] bin;
    } meta_t;

endpackage

@@ src/sbsph_db.sv @@
// ============================================================================
// sbsph_db
// Pipelined magnitude to dB converter: msb search, mantissa normalize,
// sixteen squaring stages for the log2 fraction, scale to Q8.8 dB, round and
// clamp. One item per enabled cycle.
// ============================================================================
`timescale 1ns / 1ps

module sbsph_db (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [sbsph_pkg::MAG_WIDTH-1:0]       mag,
    input  sbsph_pkg::cfg_t                       cfg,
    output logic signed [sbsph_pkg::DB_W-1:0]     level
);
    import sbsph_pkg::*;

    localparam int L_W     = POS_W + FRAC_W + 2;
    localparam int PROD_W  = L_W + DBK_W;
    localparam int DBV_W   = PROD_W - DB_SHIFT;
    localparam int WIDE_W  = MAG_WIDTH + MANT_FRAC;
    localparam int SQ_W    = 2 * MANT_W;

    logic [MAG_WIDTH-1:0]  mag1_reg;
    logic [MAG_WIDTH-1:0]  mag2_reg;
    logic [POS_W-1:0]      pos2_reg;
    logic                  zero2_reg;
    logic [POS_W-1:0]      pos_next;

    logic [MANT_W-1:0]     m_reg    [0:LOG2_STAGES];
    logic [FRAC_W-1:0]     frac_reg [0:LOG2_STAGES];
    logic [POS_W-1:0]      pos_reg  [0:LOG2_STAGES];
    logic                  zero_reg [0:LOG2_STAGES];

    logic [WIDE_W-1:0]     wide;
    logic [SQ_W-1:0]       sq       [0:LOG2_STAGES-1];
    logic [MANT_W-1:0]     m_next   [0:LOG2_STAGES-1];
    logic                  bit_next [0:LOG2_STAGES-1];

    logic [ORDER_W:0]      bias;
    logic [L_W-1:0]        l_bits;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic                  zero_p_reg;

    logic [PROD_W-1:0]     rnd_sum;
    logic signed [DBV_W-1:0] dbv;
    logic signed [DB_W-1:0] level_next;
    logic signed [DB_W-1:0] level_reg;

    always_comb
    begin
        pos_next = '0;
        for (int i = 0; i < MAG_WIDTH; i++)
        begin
            if (mag1_reg[i])
            begin
                pos_next = POS_W'(i);
            end
        end
    end

    assign wide = {mag2_reg, {MANT_FRAC{1'b0}}} >> pos2_reg;

    always_comb
    begin
        for (int g = 0; g < LOG2_STAGES; g++)
        begin
            sq[g]       = {{MANT_W{1'b0}}, m_reg[g]} * {{MANT_W{1'b0}}, m_reg[g]};
            bit_next[g] = sq[g][MANT_FRAC + MANT_W];
            m_next[g]   = bit_next[g] ? sq[g][MANT_FRAC + MANT_W:MANT_FRAC + 1]
                                      : sq[g][MANT_FRAC + MANT_W - 1:MANT_FRAC];
        end
    end

    assign bias      = (ORDER_W + 1)'(MAG_FRAC_BITS) + {1'b0, cfg.fft_order};
    assign l_bits    = L_W'({pos_reg[LOG2_STAGES], frac_reg[LOG2_STAGES]})
                     - L_W'({bias, {FRAC_W{1'b0}}});
    assign prod_next = PROD_W'($signed(l_bits)) * PROD_W'($signed({1'b0, DB_PER_LOG2}));

    assign rnd_sum = prod_reg + PROD_W'(1 << (DB_SHIFT - 1));
    assign dbv     = $signed(rnd_sum[PROD_W-1:DB_SHIFT]);

    // A zero magnitude is flagged down the pipeline and always clamps low to the Q8.8 min_db.
    always_comb
    begin
        if (zero_p_reg || (dbv < cfg.min_db))
        begin
            level_next = cfg.min_db;
        end
        else if (dbv > cfg.max_db)
        begin
            level_next = cfg.max_db;
        end
        else
        begin
            level_next = $signed(dbv[DB_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg  <= mag;
            mag2_reg  <= mag1_reg;
            pos2_reg  <= pos_next;
            zero2_reg <= (mag1_reg == '0);

            m_reg[0]    <= wide[MANT_W-1:0];
            frac_reg[0] <= '0;
            pos_reg[0]  <= pos2_reg;
            zero_reg[0] <= zero2_reg;
            for (int g = 0; g < LOG2_STAGES; g++)
            begin
                m_reg[g+1]    <= m_next[g];
                frac_reg[g+1] <= {frac_reg[g][FRAC_W-2:0], bit_next[g]};
                pos_reg[g+1]  <= pos_reg[g];
                zero_reg[g+1] <= zero_reg[g];
            end

            prod_reg   <= prod_next;
            zero_p_reg <= zero_reg[LOG2_STAGES];
            level_reg  <= level_next;
        end
    end

    assign level = level_reg;

endmodule

@@ src/spectrum_bin_smoother_peak_hold.sv @@
// ============================================================================
// spectrum_bin_smoother_peak_hold
// Converts FFT bin magnitudes to clamped Q8.8 dB levels, smooths each bin
// against its stored level with attack and release coefficients, and keeps a
// decaying peak per bin. The block takes one item per clock cycle, with any
// mix of bins, while the output is not stalled and no clearing pass runs. Items
// pass the 21 stages of the dB pipeline, sixteen of them squarings for the log2
// fraction, with the registered read of the level and peak memories alongside
// the last one, then a write stage and the output register. Items on the same
// bin close together are handled by forwarding from the write stage and the
// stage after it. After reset, a clearing pass over all 4096 bins sets every
// stored level and peak to the reset value of min_db; no item is accepted
// until it ends, while configuration writes are taken at any time.
// ============================================================================
`timescale 1ns / 1ps

module spectrum_bin_smoother_peak_hold (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_we,
    input  logic [sbsph_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sbsph_pkg::CFG_DATA_W-1:0]       cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             op,
    input  logic [sbsph_pkg::BIN_W-1:0]            bin_index,
    input  logic [sbsph_pkg::MAG_WIDTH-1:0]        magnitude,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [sbsph_pkg::BIN_W-1:0]            bin_out,
    output logic signed [sbsph_pkg::DB_W-1:0]      level_db,
    output logic signed [sbsph_pkg::DB_W-1:0]      smoothed_db,
    output logic signed [sbsph_pkg::DB_W-1:0]      peak_db
);
    import sbsph_pkg::*;

    localparam int RD_STAGE = DB_LAT;
    localparam int WR_STAGE = DB_LAT + 1;
    localparam int SM_W     = DB_W + COEFF_W + 2;
    localparam int DK_W     = DB_W + COEFF_W + 1;

    function automatic logic in_range(input logic [BIN_W-1:0] b);
        in_range = {1'b0, b} < (BIN_W + 1)'(MAX_BINS);
    endfunction

    cfg_t                   cfg_reg;
    logic [CNT_W-1:0]       clr_cnt_reg;
    logic                   clearing;
    logic                   adv;
    logic                   accept_item;

    meta_t                  meta_reg [1:WR_STAGE];
    meta_t                  mx;
    meta_t                  mw;

    logic signed [DB_W-1:0] level_x;

    logic [DB_W-1:0]        level_mem [MAX_BINS];
    logic [DB_W-1:0]        peak_mem  [MAX_BINS];
    logic [DB_W-1:0]        level_rd_reg;
    logic [DB_W-1:0]        peak_rd_reg;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic                   mem_we;
    logic [DB_W-1:0]        wr_level;
    logic [DB_W-1:0]        wr_peak;
    logic                   w_write;

    logic                   wb_valid_reg;
    logic [BIN_W-1:0]       wb_bin_reg;
    logic signed [DB_W-1:0] wb_level_reg;
    logic signed [DB_W-1:0] wb_peak_reg;

    logic signed [DB_W-1:0] prev_x;
    logic signed [DB_W-1:0] peak_x;
    logic signed [DB_W:0]   diff_x;
    logic [COEFF_W-1:0]     coeff_x;
    logic signed [SM_W-1:0] sm_prod;
    logic [SM_W-1:0]        sm_sum;
    logic [DB_W-1:0]        smooth_calc;
    logic signed [DK_W-1:0] dk_prod;
    logic [DK_W-1:0]        dk_sum;
    logic signed [DB_W-1:0] smooth_x;
    logic signed [DB_W-1:0] dpk_x;
    logic signed [DB_W-1:0] lvl_x;

    logic signed [DB_W-1:0] w_smooth_reg;
    logic signed [DB_W-1:0] w_dpk_reg;
    logic signed [DB_W-1:0] w_level_reg;
    logic signed [DB_W-1:0] w_peak;

    logic                   out_valid_reg;
    logic [BIN_W-1:0]       bin_out_reg;
    logic signed [DB_W-1:0] level_out_reg;
    logic signed [DB_W-1:0] smooth_out_reg;
    logic signed [DB_W-1:0] peak_out_reg;

    assign clearing    = clr_cnt_reg < CNT_W'(MAX_BINS);
    assign adv         = !(out_valid_reg && out_stall);
    assign in_stall    = !adv || clearing;
    assign accept_item = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FFT_ORDER: cfg_reg.fft_order     <= cfg_data[ORDER_W-1:0];
                CFG_MIN_DB:    cfg_reg.min_db        <= $signed(cfg_data[DB_W-1:0]);
                CFG_MAX_DB:    cfg_reg.max_db        <= $signed(cfg_data[DB_W-1:0]);
                CFG_ATTACK:    cfg_reg.attack_coeff  <= cfg_data[COEFF_W-1:0];
                CFG_RELEASE:   cfg_reg.release_coeff <= cfg_data[COEFF_W-1:0];
                CFG_DECAY:     cfg_reg.decay_factor  <= cfg_data[COEFF_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (clearing)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= WR_STAGE; s++)
            begin
                meta_reg[s] <= '0;
            end
        end
        else if (adv)
        begin
            meta_reg[1] <= '{valid: accept_item, op: op, bin: bin_index};
            for (int s = 2; s <= WR_STAGE; s++)
            begin
                meta_reg[s] <= meta_reg[s-1];
            end
        end
    end

    sbsph_db u_db (
        .clk   (clk),
        .en    (adv),
        .mag   (magnitude),
        .cfg   (cfg_reg),
        .level (level_x)
    );

    assign mx = meta_reg[RD_STAGE];
    assign mw = meta_reg[WR_STAGE];

    assign rd_addr  = meta_reg[RD_STAGE-1].bin[ADDR_W-1:0];
    assign w_write  = mw.valid && in_range(mw.bin);
    assign mem_we   = clearing || (adv && w_write);
    assign wr_addr  = clearing ? clr_cnt_reg[ADDR_W-1:0] : mw.bin[ADDR_W-1:0];
    assign wr_level = clearing ? RESET_MIN_DB : w_smooth_reg;
    assign wr_peak  = clearing ? RESET_MIN_DB : w_peak;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            level_mem[wr_addr] <= wr_level;
        end
        if (adv)
        begin
            level_rd_reg <= level_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            peak_mem[wr_addr] <= wr_peak;
        end
        if (adv)
        begin
            peak_rd_reg <= peak_mem[rd_addr];
        end
    end

    // The item in the write stage and the one that left it last are not yet
    // visible in the read data of the item being smoothed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            wb_valid_reg <= w_write;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wb_bin_reg   <= mw.bin;
            wb_level_reg <= w_smooth_reg;
            wb_peak_reg  <= w_peak;
        end
    end

    always_comb
    begin
        if (!in_range(mx.bin))
        begin
            prev_x = cfg_reg.min_db;
            peak_x = cfg_reg.min_db;
        end
        else if (w_write && (mw.bin == mx.bin))
        begin
            prev_x = w_smooth_reg;
            peak_x = w_peak;
        end
        else if (wb_valid_reg && (wb_bin_reg == mx.bin))
        begin
            prev_x = wb_level_reg;
            peak_x = wb_peak_reg;
        end
        else
        begin
            prev_x = $signed(level_rd_reg);
            peak_x = $signed(peak_rd_reg);
        end
    end

    assign diff_x      = {level_x[DB_W-1], level_x} - {prev_x[DB_W-1], prev_x};
    assign coeff_x     = (level_x > prev_x) ? cfg_reg.attack_coeff : cfg_reg.release_coeff;
    assign sm_prod     = SM_W'($signed({1'b0, coeff_x})) * SM_W'(diff_x);
    assign sm_sum      = sm_prod + SM_W'(1 << (COEFF_W - 1));
    assign smooth_calc = prev_x + sm_sum[COEFF_W + DB_W - 1:COEFF_W];
    assign dk_prod     = DK_W'(peak_x) * DK_W'($signed({1'b0, cfg_reg.decay_factor}));
    assign dk_sum      = dk_prod + DK_W'(1 << (COEFF_W - 1));

    always_comb
    begin
        case (mx.op)
            OP_PROCESS:
            begin
                smooth_x = $signed(smooth_calc);
                dpk_x    = $signed(dk_sum[COEFF_W + DB_W - 1:COEFF_W]);
                lvl_x    = level_x;
            end
            OP_CLEAR_PEAK:
            begin
                smooth_x = prev_x;
                dpk_x    = cfg_reg.min_db;
                lvl_x    = '0;
            end
            OP_CLEAR_ALL:
            begin
                smooth_x = cfg_reg.min_db;
                dpk_x    = cfg_reg.min_db;
                lvl_x    = '0;
            end
            default:
            begin
                smooth_x = prev_x;
                dpk_x    = peak_x;
                lvl_x    = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_smooth_reg <= smooth_x;
            w_dpk_reg    <= dpk_x;
            w_level_reg  <= lvl_x;
        end
    end

    assign w_peak = ((mw.op == OP_PROCESS) && (w_smooth_reg > w_dpk_reg)) ? w_smooth_reg
                                                                          : w_dpk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= mw.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bin_out_reg    <= mw.bin;
            level_out_reg  <= w_level_reg;
            smooth_out_reg <= w_smooth_reg;
            peak_out_reg   <= w_peak;
        end
    end

    assign out_valid   = out_valid_reg;
    assign bin_out     = bin_out_reg;
    assign level_db    = level_out_reg;
    assign smoothed_db = smooth_out_reg;
    assign peak_db     = peak_out_reg;

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !out_valid_reg)
        else $error("Result present during the clearing pass.");

    a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !meta_reg[WR_STAGE].valid)
        else $error("Item in the write stage during the clearing pass.");

    a_freeze_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(meta_reg[WR_STAGE]) && $stable(meta_reg[RD_STAGE]))
        else $error("Pipeline moved while the output was stalled.");

endmodule

@@ tb/spectrum_bin_smoother_peak_hold_tb.sv @@
// ============================================================================
// spectrum_bin_smoother_peak_hold_tb
// Self-checking testbench for the spectrum bin smoother with peak hold. Each
// accepted item is run through a behavioral model of the dB conversion, the
// attack and release smoothing and the decaying peak per bin. The model keeps
// its own copy of the level and peak memories and of the registers. Each
// result is compared field by field with the oldest expected one. Directed
// items cover the field extremes, every op and the clamp corners. Random
// frames over small groups of bins follow, under several register settings,
// with random idle cycles on both channels.
// ============================================================================
`timescale 1ns / 1ps

module spectrum_bin_smoother_peak_hold_tb;

    import sbsph_pkg::*;

    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam longint     DB_PER_OCTAVE   = 394566;
    localparam longint     ZERO_MAG_DB     = -51200;
    localparam int         SETTLE_CYCLES   = DB_LAT + 8;
    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         RANDOM_PHASES   = 6;
    localparam int         ITEMS_PER_PHASE = 125;

    typedef struct {
        logic [BIN_W-1:0]       bin;
        logic signed [DB_W-1:0] level;
        logic signed [DB_W-1:0] smooth;
        logic signed [DB_W-1:0] peak;
    } bin_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             op = OP_PROCESS;
    logic [BIN_W-1:0]       bin_index = '0;
    logic [MAG_WIDTH-1:0]   magnitude = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [BIN_W-1:0]       bin_out;
    logic signed [DB_W-1:0] level_db;
    logic signed [DB_W-1:0] smoothed_db;
    logic signed [DB_W-1:0] peak_db;

    cfg_t                   shadow_cfg;
    logic signed [DB_W-1:0] level_mem [MAX_BINS];
    logic signed [DB_W-1:0] peak_mem [MAX_BINS];
    bin_result_t            pending_results [$];
    int                     error_count = 0;
    int                     cycle_count = 0;
    int                     items_sent = 0;
    int                     stall_left = 0;
    bit                     send_idle = 1'b1;
    bit                     take_idle = 1'b1;

    spectrum_bin_smoother_peak_hold dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .bin_index   (bin_index),
        .magnitude   (magnitude),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bin_out     (bin_out),
        .level_db    (level_db),
        .smoothed_db (smoothed_db),
        .peak_db     (peak_db)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic longint round_half_up(input longint x, input int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint log2_fixed(input logic [MAG_WIDTH-1:0] v);
        int          msb;
        logic [63:0] mant;
        longint      frac;
        msb = 0;
        frac = 0;
        for (int i = 0; i < MAG_WIDTH; i++)
            if (v[i])
                msb = i;
        if (msb <= 30)
            mant = 64'(v) << (30 - msb);
        else
            mant = 64'(v) >> (msb - 30);
        for (int i = 0; i < 16; i++)
        begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= 64'h8000_0000)
            begin
                mant = mant >> 1;
                frac = frac + 1;
            end
        end
        return (longint'(msb) <<< 16) + frac;
    endfunction

    function automatic logic signed [DB_W-1:0] magnitude_to_db(
        input logic [MAG_WIDTH-1:0] mag);
        longint db;
        longint octaves;
        if (mag == 0)
            db = ZERO_MAG_DB;
        else
        begin
            octaves = log2_fixed(mag) - (longint'(16 + shadow_cfg.fft_order) <<< 16);
            db = round_half_up(octaves * DB_PER_OCTAVE, 24);
        end
        if (db < longint'($signed(shadow_cfg.min_db)))
            db = longint'($signed(shadow_cfg.min_db));
        else if (db > longint'($signed(shadow_cfg.max_db)))
            db = longint'($signed(shadow_cfg.max_db));
        return db[DB_W-1:0];
    endfunction

    function automatic void predict_bin(input logic [1:0] item_op,
                                        input logic [BIN_W-1:0] item_bin,
                                        input logic [MAG_WIDTH-1:0] item_mag);
        logic signed [DB_W-1:0] prev;
        logic signed [DB_W-1:0] peak;
        bin_result_t            res;
        longint                 coeff;
        longint                 smooth;
        longint                 decayed;
        prev = level_mem[item_bin];
        peak = peak_mem[item_bin];
        res.bin = item_bin;
        res.level = '0;
        res.smooth = prev;
        res.peak = peak;
        case (item_op)
            OP_PROCESS:
            begin
                res.level = magnitude_to_db(item_mag);
                coeff = (res.level > prev) ? longint'(shadow_cfg.attack_coeff)
                                           : longint'(shadow_cfg.release_coeff);
                smooth = longint'(prev)
                       + round_half_up(coeff * (longint'(res.level) - longint'(prev)), 16);
                decayed = round_half_up(longint'(peak) * longint'(shadow_cfg.decay_factor), 16);
                res.smooth = smooth[DB_W-1:0];
                res.peak = (smooth > decayed) ? smooth[DB_W-1:0] : decayed[DB_W-1:0];
            end
            OP_CLEAR_PEAK:
                res.peak = shadow_cfg.min_db;
            OP_CLEAR_ALL:
            begin
                res.smooth = shadow_cfg.min_db;
                res.peak = shadow_cfg.min_db;
            end
            default:
                ;
        endcase
        level_mem[item_bin] = res.smooth;
        peak_mem[item_bin] = res.peak;
        pending_results.push_back(res);
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        bin_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (pending_results.size() == 0)
                report_error($sformatf("unexpected result for bin %0d", bin_out));
            else
            begin
                want = pending_results.pop_front();
                if (bin_out !== want.bin)
                    report_error($sformatf("bin_out got %0d, expected %0d",
                                           bin_out, want.bin));
                if (level_db !== want.level)
                    report_error($sformatf("bin %0d: level_db got %0d, expected %0d",
                                           want.bin, level_db, want.level));
                if (smoothed_db !== want.smooth)
                    report_error($sformatf("bin %0d: smoothed_db got %0d, expected %0d",
                                           want.bin, smoothed_db, want.smooth));
                if (peak_db !== want.peak)
                    report_error($sformatf("bin %0d: peak_db got %0d, expected %0d",
                                           want.bin, peak_db, want.peak));
            end
        end
    end

    always @(posedge clk)
    begin
        int draw;
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= (stall_left > 1);
        end
        else if (out_valid === 1'b1 && out_stall == 1'b0)
        begin
            draw = take_idle ? $urandom_range(0, 8) : 0;
            stall_left <= draw;
            out_stall <= (draw != 0);
        end
    end

    task automatic send_item(input logic [1:0] item_op,
                             input logic [BIN_W-1:0] item_bin,
                             input logic [MAG_WIDTH-1:0] item_mag);
        int gap;
        gap = send_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= item_op;
        bin_index <= item_bin;
        magnitude <= item_mag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_bin(item_op, item_bin, item_mag);
        items_sent++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            CFG_FFT_ORDER: shadow_cfg.fft_order = data[ORDER_W-1:0];
            CFG_MIN_DB:    shadow_cfg.min_db = data;
            CFG_MAX_DB:    shadow_cfg.max_db = data;
            CFG_ATTACK:    shadow_cfg.attack_coeff = data;
            CFG_RELEASE:   shadow_cfg.release_coeff = data;
            CFG_DECAY:     shadow_cfg.decay_factor = data;
            default:       ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_config(input cfg_t c);
        write_register(CFG_FFT_ORDER, CFG_DATA_W'(c.fft_order));
        write_register(CFG_MIN_DB, c.min_db);
        write_register(CFG_MAX_DB, c.max_db);
        write_register(CFG_ATTACK, c.attack_coeff);
        write_register(CFG_RELEASE, c.release_coeff);
        write_register(CFG_DECAY, c.decay_factor);
    endtask

    function automatic cfg_t random_settings();
        cfg_t c;
        int   lo;
        int   hi;
        c.fft_order = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(10, 13)) : 4'($urandom);
        lo = -int'($urandom_range(0, 32768));
        if ($urandom_range(0, 6) != 0)
            hi = lo + int'($urandom_range(0, 32767 - lo));
        else
            hi = int'($urandom_range(0, 65535)) - 32768;
        c.min_db = 16'(lo);
        c.max_db = 16'(hi);
        c.attack_coeff = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
        c.release_coeff = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
        c.decay_factor = 16'($urandom_range(52429, 65470));
        return c;
    endfunction

    task automatic test_reset_defaults();
        send_item(OP_PROCESS, 12'd0, 32'h0000_0000);
        send_item(OP_PROCESS, 12'hFFF, 32'hFFFF_FFFF);
        send_item(OP_PROCESS, 12'hFFF, 32'h0000_0001);
        send_idle = 1'b0;
        send_item(OP_PROCESS, 12'h007, 32'h0400_0000);
        send_item(OP_PROCESS, 12'h007, 32'h0000_4000);
        send_item(OP_PROCESS, 12'h007, 32'hAAAA_5555);
        send_item(OP_CLEAR_PEAK, 12'h007, 32'h5555_AAAA);
        send_item(OP_PROCESS, 12'h007, 32'h0100_0000);
        send_idle = 1'b1;
        send_item(OP_CLEAR_ALL, 12'hFFF, 32'hFFFF_FFFF);
        send_item(OP_UNUSED, 12'h007, 32'hFFFF_FFFF);
    endtask

    task automatic test_clamp_extremes();
        wait_for_results();
        write_register(CFG_FFT_ORDER, 16'hFFF0);
        write_register(CFG_MIN_DB, 16'h8000);
        write_register(CFG_MAX_DB, 16'h7FFF);
        send_item(OP_CLEAR_ALL, 12'd0, 32'h0000_0000);
        send_item(OP_PROCESS, 12'd0, 32'hFFFF_FFFF);
        send_item(OP_PROCESS, 12'd1, 32'h0000_0000);
        wait_for_results();
        write_register(CFG_FFT_ORDER, 16'h000F);
        send_item(OP_PROCESS, 12'd1, 32'h0000_0001);
        wait_for_results();
        write_register(CFG_MIN_DB, 16'(-1280));
        write_register(CFG_MAX_DB, 16'(-5120));
        send_item(OP_PROCESS, 12'd2, 32'h0000_0000);
        send_item(OP_PROCESS, 12'd2, 32'hFFFF_FFFF);
        send_item(OP_CLEAR_PEAK, 12'd2, 32'h0000_0000);
    endtask

    task automatic test_coefficient_extremes();
        wait_for_results();
        apply_config(CFG_RESET);
        write_register(CFG_ATTACK, 16'h0000);
        write_register(CFG_RELEASE, 16'h0000);
        send_item(OP_PROCESS, 12'd100, 32'hFFFF_FFFF);
        send_item(OP_PROCESS, 12'd100, 32'h0000_0000);
        wait_for_results();
        write_register(CFG_ATTACK, 16'hFFFF);
        write_register(CFG_RELEASE, 16'hFFFF);
        write_register(CFG_DECAY, 16'h0000);
        send_item(OP_PROCESS, 12'd100, 32'hFFFF_FFFF);
        send_item(OP_PROCESS, 12'd100, 32'h0000_0010);
        wait_for_results();
        write_register(CFG_DECAY, 16'hFFFF);
        send_item(OP_PROCESS, 12'd100, 32'h0000_0000);
        wait_for_results();
        write_register(CFG_DECAY, 16'd52429);
        send_item(OP_PROCESS, 12'd100, 32'h0000_0000);
        wait_for_results();
        write_register(CFG_DECAY, 16'd65470);
        send_item(OP_PROCESS, 12'd100, 32'h0000_0000);
    endtask

    task automatic test_random_frames();
        int               target;
        int               pick;
        int               nbins;
        int               frames;
        int               shift_of [6];
        logic [BIN_W-1:0] base;
        logic [MAG_WIDTH-1:0] mag;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_for_results();
            if (phase == 0)
                apply_config(CFG_RESET);
            else
                apply_config(random_settings());
            send_idle = (phase % 3 != 1);
            take_idle = (phase % 3 != 2);
            target = items_sent + ITEMS_PER_PHASE;
            base = BIN_W'($urandom);
            while (items_sent < target)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 15)
                begin
                    nbins = $urandom_range(1, 6);
                    frames = $urandom_range(2, 8);
                    base = BIN_W'($urandom);
                    for (int k = 0; k < nbins; k++)
                        shift_of[k] = $urandom_range(0, 31);
                    for (int f = 0; f < frames; f++)
                    begin
                        for (int k = 0; k < nbins; k++)
                        begin
                            if ($urandom_range(0, 7) == 0)
                                shift_of[k] = $urandom_range(0, 31);
                            else
                                shift_of[k] = shift_of[k] + int'($urandom_range(0, 6)) - 3;
                            if (shift_of[k] < 0)
                                shift_of[k] = 0;
                            if (shift_of[k] > 31)
                                shift_of[k] = 31;
                            mag = (32'h8000_0000 | $urandom) >> shift_of[k];
                            if ($urandom_range(0, 19) == 0)
                                mag = '0;
                            send_item(OP_PROCESS, base + BIN_W'(k), mag);
                        end
                    end
                end
                else if (pick < 17)
                    send_item(($urandom_range(0, 1) != 0) ? OP_CLEAR_PEAK : OP_CLEAR_ALL,
                              base + BIN_W'($urandom_range(0, 5)), $urandom);
                else if (pick == 17)
                    send_item(OP_UNUSED, base + BIN_W'($urandom_range(0, 5)), $urandom);
                else
                    send_item(2'($urandom_range(0, 3)), BIN_W'($urandom), $urandom);
                if ($urandom_range(0, 5) == 0)
                    send_idle = !send_idle;
                if ($urandom_range(0, 5) == 0)
                    take_idle = !take_idle;
            end
        end
    endtask

    initial
    begin
        shadow_cfg = CFG_RESET;
        for (int i = 0; i < MAX_BINS; i++)
        begin
            level_mem[i] = RESET_MIN_DB;
            peak_mem[i] = RESET_MIN_DB;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_clamp_extremes();
        test_coefficient_extremes();
        test_random_frames();
        wait_for_results();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
src/sbsph_pkg.sv
src/sbsph_db.sv
src/spectrum_bin_smoother_peak_hold.sv
tb/spectrum_bin_smoother_peak_hold_tb.sv
